// File: sv/iaqu_pkg.sv
// shared types, constants and helper functions of the attitude update block
package iaqu_pkg;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STEP_TIME = 2'd1;

  // register reset values
  localparam logic [23:0] PropGainRst = 24'd131072;
  localparam logic [31:0] StepTimeRst = 32'd4294967;

  // one in Q2.30
  localparam logic [31:0] Q30One = 32'h4000_0000;

  // multiply-accumulate widths
  localparam int OpW   = 35;
  localparam int ProdW = 70;
  localparam int AccW  = 72;

  // product program
  localparam int StepW = 6;
  localparam logic [StepW-1:0] StepSEnd  = 6'd2;
  localparam logic [StepW-1:0] StepNqEnd = 6'd39;
  localparam logic [StepW-1:0] LastStep  = 6'd43;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_RSQ,
    ST_NDIV,
    ST_NORM,
    ST_NSQ,
    ST_QDIV,
    ST_DONE
  } state_e;

  // destination of a finished sum of products
  typedef enum logic [3:0] {
    DST_NONE,
    DST_S,
    DST_VX,
    DST_VY,
    DST_VZ,
    DST_E,
    DST_G,
    DST_T,
    DST_NQ,
    DST_N2
  } dst_e;

  typedef enum logic {
    MODE_SQRT,
    MODE_DIV
  } itr_mode_e;

  typedef struct packed {
    logic      start;
    itr_mode_e mode;
  } itr_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } itr_rsp_t;

  typedef struct packed {
    logic signed [OpW-1:0] opa;
    logic signed [OpW-1:0] opb;
    logic                  neg;
    logic                  shr;
    logic                  first;
    dst_e                  dst;
    logic [1:0]            cidx;
  } mac_op_t;

  function automatic logic signed [OpW-1:0] sx32(input logic [31:0] x);
    return $signed({{3{x[31]}}, x});
  endfunction

  function automatic logic signed [OpW-1:0] sx16(input logic [15:0] x);
    return $signed({{19{x[15]}}, x});
  endfunction

  function automatic logic signed [OpW-1:0] zx32(input logic [31:0] x);
    return $signed({3'b000, x});
  endfunction

  function automatic logic [31:0] sat32(input logic signed [AccW-1:0] x);
    if (x > 72'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (x < -72'sd2147483648) begin
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

// File: sv/iaqu_if.sv
// item channels: sensor sample in, attitude result out

interface iaqu_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] accel_x;
  logic [15:0] accel_y;
  logic [15:0] accel_z;
  logic [31:0] rate_roll;
  logic [31:0] rate_pitch;
  logic [31:0] rate_yaw;

  modport source (
    output valid, accel_x, accel_y, accel_z, rate_roll, rate_pitch, rate_yaw,
    input  ready
  );
  modport sink (
    input  valid, accel_x, accel_y, accel_z, rate_roll, rate_pitch, rate_yaw,
    output ready
  );
endinterface

interface iaqu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] quat_w;
  logic [31:0] quat_x;
  logic [31:0] quat_y;
  logic [31:0] quat_z;
  logic [31:0] fixed_roll;
  logic [31:0] fixed_pitch;
  logic [31:0] fixed_yaw;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z, fixed_roll, fixed_pitch, fixed_yaw,
    input  ready
  );
  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z, fixed_roll, fixed_pitch, fixed_yaw,
    output ready
  );
endinterface

// File: sv/imu_quaternion_attitude_update_top.sv
// top level: iterative quaternion attitude update from accelerometer and gyro items
//
// One item is taken, then the block is busy until its result is loaded into
// the output register before it takes the next. With a zero accelerometer
// vector the first square root and the unit vector divisions are skipped;
// with all four integrated components zero, the squared norm, its square
// root and the quaternion divisions are skipped too. Up to forty-four
// products run through one 35x35 multiplier and accumulator, each in a
// multiply phase and an accumulate phase; a bit-serial unit does two integer
// square roots and seven divisions (three for the unit accelerometer vector,
// four for the renormalized quaternion); a one-bit shifter brings the largest
// quaternion component into range. The finished result waits in an output
// register, so a new item is accepted while the previous result has not yet
// been taken. Configuration writes take effect at once and belong between items.
module imu_quaternion_attitude_update_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iaqu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [iaqu_pkg::CfgDataW-1:0] cfg_data_i,
  iaqu_in_if.sink                       in_chan,
  iaqu_out_if.source                    out_chan
);

  iaqu_pkg::state_e state_q, state_d;

  // configuration
  logic [23:0] pg_q;
  logic [31:0] st_time_q;

  // item and intermediate values
  logic [15:0]                        ax_q, ay_q, az_q;
  logic [31:0]                        rate_q [3];
  logic [31:0]                        q_q    [4];
  logic [31:0]                        n_q    [3];
  logic [31:0]                        v_q    [3];
  logic signed [iaqu_pkg::OpW-1:0]    e_q    [3];
  logic [31:0]                        g_q    [3];
  logic [31:0]                        s_q, r_q, nrm_q;
  logic [63:0]                        n2_q;
  logic [47:0]                        m_q;
  logic                               tneg_q;
  logic [47:0]                        mg_q   [4];
  logic                               mneg_q [4];
  logic [31:0]                        nq_out_q [4];

  // sequencer
  logic [iaqu_pkg::StepW-1:0] step_q;
  logic                       ph_q;
  logic [1:0]                 cidx_q;
  logic                       itr_run_q;

  // multiply-accumulate
  iaqu_pkg::mac_op_t                 mop;
  logic signed [iaqu_pkg::ProdW-1:0] prod_d, prod_q;
  logic signed [iaqu_pkg::AccW-1:0]  acc_q;
  logic signed [iaqu_pkg::AccW-1:0]  prod_ext, term, acc_sum;
  logic signed [iaqu_pkg::AccW-1:0]  acc_sh29, acc_sh30, acc_sh17, acc_abs;
  logic signed [iaqu_pkg::AccW-1:0]  rate_ext, g_sum;
  logic [31:0]                       rate_sel;
  logic signed [48:0]                hs_ext, nq_sum;
  logic [48:0]                       nq_abs;

  // iterative unit
  iaqu_pkg::itr_req_t itr_req;
  iaqu_pkg::itr_rsp_t itr_rsp;
  logic [63:0]        itr_opa;
  logic [31:0]        itr_opb;
  logic [63:0]        itr_res;

  // misc
  logic        in_acc, out_free, out_load, out_valid_q;
  logic [15:0] amag;
  logic        asgn;
  logic [31:0] nclamp;
  logic        mg_zero, mg_hi, mg_lo;
  logic [31:0] outq_q [4];
  logic [31:0] outg_q [3];

  iaqu_itr u_itr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (itr_req),
    .opa_i  (itr_opa),
    .opb_i  (itr_opb),
    .rsp_o  (itr_rsp),
    .res_o  (itr_res)
  );

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_q || out_chan.ready;
  assign out_load = (state_q == iaqu_pkg::ST_DONE) && out_free;

  // product program decoder
  always_comb begin
    mop       = '0;
    mop.dst   = iaqu_pkg::DST_NONE;
    unique case (step_q)
      6'd0:  begin mop.opa = iaqu_pkg::sx16(ax_q); mop.opb = iaqu_pkg::sx16(ax_q);
                   mop.first = 1'b1; end
      6'd1:  begin mop.opa = iaqu_pkg::sx16(ay_q); mop.opb = iaqu_pkg::sx16(ay_q); end
      6'd2:  begin mop.opa = iaqu_pkg::sx16(az_q); mop.opb = iaqu_pkg::sx16(az_q);
                   mop.dst = iaqu_pkg::DST_S; end
      6'd3:  begin mop.opa = iaqu_pkg::sx32(q_q[1]); mop.opb = iaqu_pkg::sx32(q_q[3]);
                   mop.first = 1'b1; end
      6'd4:  begin mop.opa = iaqu_pkg::sx32(q_q[0]); mop.opb = iaqu_pkg::sx32(q_q[2]);
                   mop.neg = 1'b1; mop.dst = iaqu_pkg::DST_VX; end
      6'd5:  begin mop.opa = iaqu_pkg::sx32(q_q[0]); mop.opb = iaqu_pkg::sx32(q_q[1]);
                   mop.first = 1'b1; end
      6'd6:  begin mop.opa = iaqu_pkg::sx32(q_q[2]); mop.opb = iaqu_pkg::sx32(q_q[3]);
                   mop.dst = iaqu_pkg::DST_VY; end
      6'd7:  begin mop.opa = iaqu_pkg::sx32(q_q[0]); mop.opb = iaqu_pkg::sx32(q_q[0]);
                   mop.first = 1'b1; end
      6'd8:  begin mop.opa = iaqu_pkg::sx32(q_q[1]); mop.opb = iaqu_pkg::sx32(q_q[1]);
                   mop.neg = 1'b1; end
      6'd9:  begin mop.opa = iaqu_pkg::sx32(q_q[2]); mop.opb = iaqu_pkg::sx32(q_q[2]);
                   mop.neg = 1'b1; end
      6'd10: begin mop.opa = iaqu_pkg::sx32(q_q[3]); mop.opb = iaqu_pkg::sx32(q_q[3]);
                   mop.dst = iaqu_pkg::DST_VZ; end
      6'd11: begin mop.opa = iaqu_pkg::sx32(n_q[1]); mop.opb = iaqu_pkg::sx32(v_q[2]);
                   mop.first = 1'b1; end
      6'd12: begin mop.opa = iaqu_pkg::sx32(n_q[2]); mop.opb = iaqu_pkg::sx32(v_q[1]);
                   mop.neg = 1'b1; mop.dst = iaqu_pkg::DST_E; mop.cidx = 2'd0; end
      6'd13: begin mop.opa = iaqu_pkg::sx32(n_q[2]); mop.opb = iaqu_pkg::sx32(v_q[0]);
                   mop.first = 1'b1; end
      6'd14: begin mop.opa = iaqu_pkg::sx32(n_q[0]); mop.opb = iaqu_pkg::sx32(v_q[2]);
                   mop.neg = 1'b1; mop.dst = iaqu_pkg::DST_E; mop.cidx = 2'd1; end
      6'd15: begin mop.opa = iaqu_pkg::sx32(n_q[0]); mop.opb = iaqu_pkg::sx32(v_q[1]);
                   mop.first = 1'b1; end
      6'd16: begin mop.opa = iaqu_pkg::sx32(n_q[1]); mop.opb = iaqu_pkg::sx32(v_q[0]);
                   mop.neg = 1'b1; mop.dst = iaqu_pkg::DST_E; mop.cidx = 2'd2; end
      6'd17: begin mop.opa = iaqu_pkg::zx32({8'd0, pg_q}); mop.opb = e_q[0];
                   mop.first = 1'b1; mop.dst = iaqu_pkg::DST_G; mop.cidx = 2'd0; end
      6'd18: begin mop.opa = iaqu_pkg::zx32({8'd0, pg_q}); mop.opb = e_q[1];
                   mop.first = 1'b1; mop.dst = iaqu_pkg::DST_G; mop.cidx = 2'd1; end
      6'd19: begin mop.opa = iaqu_pkg::zx32({8'd0, pg_q}); mop.opb = e_q[2];
                   mop.first = 1'b1; mop.dst = iaqu_pkg::DST_G; mop.cidx = 2'd2; end
      // scalar part rate terms
      6'd20: begin mop.opa = iaqu_pkg::sx32(q_q[1]); mop.opb = iaqu_pkg::sx32(g_q[0]);
                   mop.first = 1'b1; mop.neg = 1'b1; mop.shr = 1'b1; end
      6'd21: begin mop.opa = iaqu_pkg::sx32(q_q[2]); mop.opb = iaqu_pkg::sx32(g_q[1]);
                   mop.neg = 1'b1; mop.shr = 1'b1; end
      6'd22: begin mop.opa = iaqu_pkg::sx32(q_q[3]); mop.opb = iaqu_pkg::sx32(g_q[2]);
                   mop.neg = 1'b1; mop.shr = 1'b1; mop.dst = iaqu_pkg::DST_T; end
      6'd23: begin mop.opa = iaqu_pkg::zx32(m_q[47:16]); mop.opb = iaqu_pkg::zx32(st_time_q);
                   mop.first = 1'b1; end
      6'd24: begin mop.opa = iaqu_pkg::zx32({16'd0, m_q[15:0]});
                   mop.opb = iaqu_pkg::zx32(st_time_q); mop.shr = 1'b1;
                   mop.dst = iaqu_pkg::DST_NQ; mop.cidx = 2'd0; end
      // x part
      6'd25: begin mop.opa = iaqu_pkg::sx32(q_q[0]); mop.opb = iaqu_pkg::sx32(g_q[0]);
                   mop.first = 1'b1; mop.shr = 1'b1; end
      6'd26: begin mop.opa = iaqu_pkg::sx32(q_q[2]); mop.opb = iaqu_pkg::sx32(g_q[2]);
                   mop.shr = 1'b1; end
      6'd27: begin mop.opa = iaqu_pkg::sx32(q_q[3]); mop.opb = iaqu_pkg::sx32(g_q[1]);
                   mop.neg = 1'b1; mop.shr = 1'b1; mop.dst = iaqu_pkg::DST_T; end
      6'd28: begin mop.opa = iaqu_pkg::zx32(m_q[47:16]); mop.opb = iaqu_pkg::zx32(st_time_q);
                   mop.first = 1'b1; end
      6'd29: begin mop.opa = iaqu_pkg::zx32({16'd0, m_q[15:0]});
                   mop.opb = iaqu_pkg::zx32(st_time_q); mop.shr = 1'b1;
                   mop.dst = iaqu_pkg::DST_NQ; mop.cidx = 2'd1; end
      // y part
      6'd30: begin mop.opa = iaqu_pkg::sx32(q_q[0]); mop.opb = iaqu_pkg::sx32(g_q[1]);
                   mop.first = 1'b1; mop.shr = 1'b1; end
      6'd31: begin mop.opa = iaqu_pkg::sx32(q_q[1]); mop.opb = iaqu_pkg::sx32(g_q[2]);
                   mop.neg = 1'b1; mop.shr = 1'b1; end
      6'd32: begin mop.opa = iaqu_pkg::sx32(q_q[3]); mop.opb = iaqu_pkg::sx32(g_q[0]);
                   mop.shr = 1'b1; mop.dst = iaqu_pkg::DST_T; end
      6'd33: begin mop.opa = iaqu_pkg::zx32(m_q[47:16]); mop.opb = iaqu_pkg::zx32(st_time_q);
                   mop.first = 1'b1; end
      6'd34: begin mop.opa = iaqu_pkg::zx32({16'd0, m_q[15:0]});
                   mop.opb = iaqu_pkg::zx32(st_time_q); mop.shr = 1'b1;
                   mop.dst = iaqu_pkg::DST_NQ; mop.cidx = 2'd2; end
      // z part
      6'd35: begin mop.opa = iaqu_pkg::sx32(q_q[0]); mop.opb = iaqu_pkg::sx32(g_q[2]);
                   mop.first = 1'b1; mop.shr = 1'b1; end
      6'd36: begin mop.opa = iaqu_pkg::sx32(q_q[1]); mop.opb = iaqu_pkg::sx32(g_q[1]);
                   mop.shr = 1'b1; end
      6'd37: begin mop.opa = iaqu_pkg::sx32(q_q[2]); mop.opb = iaqu_pkg::sx32(g_q[0]);
                   mop.neg = 1'b1; mop.shr = 1'b1; mop.dst = iaqu_pkg::DST_T; end
      6'd38: begin mop.opa = iaqu_pkg::zx32(m_q[47:16]); mop.opb = iaqu_pkg::zx32(st_time_q);
                   mop.first = 1'b1; end
      6'd39: begin mop.opa = iaqu_pkg::zx32({16'd0, m_q[15:0]});
                   mop.opb = iaqu_pkg::zx32(st_time_q); mop.shr = 1'b1;
                   mop.dst = iaqu_pkg::DST_NQ; mop.cidx = 2'd3; end
      // squared norm of the shifted magnitudes
      6'd40: begin mop.opa = iaqu_pkg::zx32({1'b0, mg_q[0][30:0]});
                   mop.opb = iaqu_pkg::zx32({1'b0, mg_q[0][30:0]}); mop.first = 1'b1; end
      6'd41: begin mop.opa = iaqu_pkg::zx32({1'b0, mg_q[1][30:0]});
                   mop.opb = iaqu_pkg::zx32({1'b0, mg_q[1][30:0]}); end
      6'd42: begin mop.opa = iaqu_pkg::zx32({1'b0, mg_q[2][30:0]});
                   mop.opb = iaqu_pkg::zx32({1'b0, mg_q[2][30:0]}); end
      6'd43: begin mop.opa = iaqu_pkg::zx32({1'b0, mg_q[3][30:0]});
                   mop.opb = iaqu_pkg::zx32({1'b0, mg_q[3][30:0]});
                   mop.dst = iaqu_pkg::DST_N2; end
      default: begin
        mop.dst = iaqu_pkg::DST_NONE;
      end
    endcase
  end

  // multiplier and accumulator arithmetic
  assign prod_d   = mop.opa * mop.opb;
  assign prod_ext = $signed({{2{prod_q[iaqu_pkg::ProdW-1]}}, prod_q});
  assign term     = mop.shr ? (prod_ext >>> 16) : prod_ext;
  assign acc_sum  = (mop.first ? '0 : acc_q) + (mop.neg ? -term : term);
  assign acc_sh29 = acc_sum >>> 29;
  assign acc_sh30 = acc_sum >>> 30;
  assign acc_sh17 = acc_sum >>> 17;
  assign acc_abs  = acc_sum[iaqu_pkg::AccW-1] ? -acc_sum : acc_sum;

  // corrected rate
  always_comb begin
    case (mop.cidx)
      2'd0:    rate_sel = rate_q[0];
      2'd1:    rate_sel = rate_q[1];
      default: rate_sel = rate_q[2];
    endcase
  end
  assign rate_ext = $signed({{40{rate_sel[31]}}, rate_sel});
  assign g_sum    = rate_ext + acc_sh30;

  // integrated component: old value plus signed half step
  assign hs_ext = $signed({1'b0, acc_sh17[47:0]});
  assign nq_sum = $signed({{17{q_q[mop.cidx][31]}}, q_q[mop.cidx]})
                + (tneg_q ? -hs_ext : hs_ext);
  assign nq_abs = nq_sum[48] ? -nq_sum : nq_sum;

  // accelerometer axis for the unit vector divisions
  always_comb begin
    case (cidx_q)
      2'd0:    begin amag = ax_q[15] ? -ax_q : ax_q; asgn = ax_q[15]; end
      2'd1:    begin amag = ay_q[15] ? -ay_q : ay_q; asgn = ay_q[15]; end
      default: begin amag = az_q[15] ? -az_q : az_q; asgn = az_q[15]; end
    endcase
  end
  assign nclamp = (itr_res > 64'd1073741824) ? iaqu_pkg::Q30One : itr_res[31:0];

  // range checks on the integrated magnitudes
  assign mg_zero = (mg_q[0] == '0) && (mg_q[1] == '0) && (mg_q[2] == '0) && (mg_q[3] == '0);
  assign mg_hi   = (|mg_q[0][47:31]) || (|mg_q[1][47:31]) ||
                   (|mg_q[2][47:31]) || (|mg_q[3][47:31]);
  assign mg_lo   = !(|mg_q[0][47:30]) && !(|mg_q[1][47:30]) &&
                   !(|mg_q[2][47:30]) && !(|mg_q[3][47:30]);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iaqu_pkg::ST_IDLE: begin
        if (in_acc) state_d = iaqu_pkg::ST_MAC;
      end
      iaqu_pkg::ST_MAC: begin
        if (ph_q) begin
          if (step_q == iaqu_pkg::StepSEnd) begin
            state_d = (acc_sum == '0) ? iaqu_pkg::ST_MAC : iaqu_pkg::ST_RSQ;
          end else if (step_q == iaqu_pkg::StepNqEnd) begin
            state_d = iaqu_pkg::ST_NORM;
          end else if (step_q == iaqu_pkg::LastStep) begin
            state_d = iaqu_pkg::ST_NSQ;
          end
        end
      end
      iaqu_pkg::ST_RSQ: begin
        if (itr_rsp.done) state_d = iaqu_pkg::ST_NDIV;
      end
      iaqu_pkg::ST_NDIV: begin
        if (itr_rsp.done && cidx_q == 2'd2) state_d = iaqu_pkg::ST_MAC;
      end
      iaqu_pkg::ST_NORM: begin
        if (mg_zero) begin
          state_d = iaqu_pkg::ST_DONE;
        end else if (!mg_hi && !mg_lo) begin
          state_d = iaqu_pkg::ST_MAC;
        end
      end
      iaqu_pkg::ST_NSQ: begin
        if (itr_rsp.done) state_d = iaqu_pkg::ST_QDIV;
      end
      iaqu_pkg::ST_QDIV: begin
        if (itr_rsp.done && cidx_q == 2'd3) state_d = iaqu_pkg::ST_DONE;
      end
      iaqu_pkg::ST_DONE: begin
        if (out_free) state_d = iaqu_pkg::ST_IDLE;
      end
      default: state_d = iaqu_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    itr_req.start = 1'b0;
    itr_req.mode  = iaqu_pkg::MODE_SQRT;
    itr_opa       = {s_q, 32'd0};
    itr_opb       = r_q;
    unique case (state_q)
      iaqu_pkg::ST_RSQ: begin
        itr_req.start = !itr_run_q;
      end
      iaqu_pkg::ST_NDIV: begin
        itr_req.start = !itr_run_q;
        itr_req.mode  = iaqu_pkg::MODE_DIV;
        itr_opa       = {2'b00, amag, 46'd0};
      end
      iaqu_pkg::ST_NSQ: begin
        itr_req.start = !itr_run_q;
        itr_opa       = n2_q;
      end
      iaqu_pkg::ST_QDIV: begin
        itr_req.start = !itr_run_q;
        itr_req.mode  = iaqu_pkg::MODE_DIV;
        itr_opa       = {3'b000, mg_q[cidx_q][30:0], 30'd0};
        itr_opb       = nrm_q;
      end
      default: begin
        itr_req.start = 1'b0;
      end
    endcase
  end

  assign in_chan.ready = (state_q == iaqu_pkg::ST_IDLE);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iaqu_pkg::ST_IDLE;
      step_q      <= '0;
      ph_q        <= 1'b0;
      cidx_q      <= '0;
      itr_run_q   <= 1'b0;
      out_valid_q <= 1'b0;
      pg_q        <= iaqu_pkg::PropGainRst;
      st_time_q   <= iaqu_pkg::StepTimeRst;
      q_q[0]      <= iaqu_pkg::Q30One;
      q_q[1]      <= '0;
      q_q[2]      <= '0;
      q_q[3]      <= '0;
    end else begin
      state_q <= state_d;

      // register writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          iaqu_pkg::CFG_PROP_GAIN: pg_q      <= cfg_data_i[23:0];
          iaqu_pkg::CFG_STEP_TIME: st_time_q <= cfg_data_i;
          default: ;
        endcase
      end

      // product program position
      if (in_acc) begin
        step_q <= '0;
        ph_q   <= 1'b0;
      end else if (state_q == iaqu_pkg::ST_MAC) begin
        ph_q <= !ph_q;
        if (ph_q) step_q <= step_q + 1'b1;
      end

      // iterative unit handshake and component index
      if (itr_req.start) itr_run_q <= 1'b1;
      if (itr_rsp.done) begin
        itr_run_q <= 1'b0;
        if (state_q == iaqu_pkg::ST_NDIV || state_q == iaqu_pkg::ST_QDIV) begin
          cidx_q <= cidx_q + 2'd1;
        end else begin
          cidx_q <= '0;
        end
      end

      // output register and new state
      if (out_load) begin
        out_valid_q <= 1'b1;
        for (int i = 0; i < 4; i++) q_q[i] <= nq_out_q[i];
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ax_q      <= in_chan.accel_x;
      ay_q      <= in_chan.accel_y;
      az_q      <= in_chan.accel_z;
      rate_q[0] <= in_chan.rate_roll;
      rate_q[1] <= in_chan.rate_pitch;
      rate_q[2] <= in_chan.rate_yaw;
      for (int i = 0; i < 3; i++) n_q[i] <= '0;
    end

    // two-phase multiply then accumulate
    if (state_q == iaqu_pkg::ST_MAC) begin
      if (!ph_q) begin
        prod_q <= prod_d;
      end else begin
        acc_q <= acc_sum;
        unique case (mop.dst)
          iaqu_pkg::DST_S:  s_q <= acc_sum[31:0];
          iaqu_pkg::DST_VX: v_q[0] <= iaqu_pkg::sat32(acc_sh29);
          iaqu_pkg::DST_VY: v_q[1] <= iaqu_pkg::sat32(acc_sh29);
          iaqu_pkg::DST_VZ: v_q[2] <= iaqu_pkg::sat32(acc_sh30);
          iaqu_pkg::DST_E:  e_q[mop.cidx] <= acc_sh30[iaqu_pkg::OpW-1:0];
          iaqu_pkg::DST_G:  g_q[mop.cidx] <= iaqu_pkg::sat32(g_sum);
          iaqu_pkg::DST_T: begin
            tneg_q <= acc_sum[iaqu_pkg::AccW-1];
            m_q    <= acc_abs[47:0];
          end
          iaqu_pkg::DST_NQ: begin
            mneg_q[mop.cidx] <= nq_sum[48];
            mg_q[mop.cidx]   <= nq_abs[47:0];
          end
          iaqu_pkg::DST_N2: n2_q <= acc_sum[63:0];
          default: ;
        endcase
      end
    end

    // results of the iterative unit
    if (itr_rsp.done) begin
      unique case (state_q)
        iaqu_pkg::ST_RSQ:  r_q   <= itr_res[31:0];
        iaqu_pkg::ST_NSQ:  nrm_q <= itr_res[31:0];
        iaqu_pkg::ST_NDIV: n_q[cidx_q] <= asgn ? -nclamp : nclamp;
        iaqu_pkg::ST_QDIV: nq_out_q[cidx_q] <= mneg_q[cidx_q] ? -itr_res[31:0]
                                                               : itr_res[31:0];
        default: ;
      endcase
    end

    // bring the largest magnitude into [2^30, 2^31)
    if (state_q == iaqu_pkg::ST_NORM) begin
      if (mg_zero) begin
        nq_out_q[0] <= iaqu_pkg::Q30One;
        nq_out_q[1] <= '0;
        nq_out_q[2] <= '0;
        nq_out_q[3] <= '0;
      end else if (mg_hi) begin
        for (int i = 0; i < 4; i++) mg_q[i] <= mg_q[i] >> 1;
      end else if (mg_lo) begin
        for (int i = 0; i < 4; i++) mg_q[i] <= mg_q[i] << 1;
      end
    end

    if (out_load) begin
      for (int i = 0; i < 4; i++) outq_q[i] <= nq_out_q[i];
      for (int i = 0; i < 3; i++) outg_q[i] <= g_q[i];
    end
  end

  assign out_chan.valid       = out_valid_q;
  assign out_chan.quat_w      = outq_q[0];
  assign out_chan.quat_x      = outq_q[1];
  assign out_chan.quat_y      = outq_q[2];
  assign out_chan.quat_z      = outq_q[3];
  assign out_chan.fixed_roll  = outg_q[0];
  assign out_chan.fixed_pitch = outg_q[1];
  assign out_chan.fixed_yaw   = outg_q[2];

`ifndef ASSERT_OFF
  // the iterative unit is never started while it is still working
  a_itr_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    itr_req.start |-> !itr_rsp.busy)
    else $error("iterative unit started while busy");

  // after an item is taken the block is busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_chan.ready)
    else $error("item accepted while previous one in work");

  // the product program never runs past its last step
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iaqu_pkg::ST_MAC) |-> (step_q <= iaqu_pkg::LastStep))
    else $error("product step out of range");

  // a loaded quaternion scalar part stays within unit magnitude
  a_quat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ($signed(out_chan.quat_w) <= 32'sd1073741824 &&
                  $signed(out_chan.quat_w) >= -32'sd1073741824))
    else $error("quaternion component out of range");
`endif

endmodule

// File: sv/iaqu_itr.sv
// bit-serial unit: integer square root (two bits a cycle) or 64/32 division
module iaqu_itr (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iaqu_pkg::itr_req_t req_i,
  input  logic [63:0]        opa_i,
  input  logic [31:0]        opb_i,
  output iaqu_pkg::itr_rsp_t rsp_o,
  output logic [63:0]        res_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  iaqu_pkg::itr_mode_e mode_q, mode_d;
  logic [5:0]          cnt_q, cnt_d;
  logic [63:0]         a_q, a_d;
  logic [63:0]         b_q, b_d;
  logic [63:0]         c_q, c_d;

  logic [63:0] trial;
  logic        sq_ge;
  logic [32:0] dv_tmp;
  logic        dv_ge;
  logic [32:0] dv_rem;

  // square root trial subtract
  assign trial = b_q + c_q;
  assign sq_ge = (a_q >= trial);

  // restoring division step
  assign dv_tmp = {b_q[31:0], a_q[63]};
  assign dv_ge  = (dv_tmp >= {1'b0, c_q[31:0]});
  assign dv_rem = dv_ge ? (dv_tmp - {1'b0, c_q[31:0]}) : dv_tmp;

  // iteration control and datapath
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    c_d    = c_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      mode_d = req_i.mode;
      a_d    = opa_i;
      b_d    = '0;
      if (req_i.mode == iaqu_pkg::MODE_SQRT) begin
        c_d   = 64'h4000_0000_0000_0000;
        cnt_d = 6'd31;
      end else begin
        c_d   = {32'd0, opb_i};
        cnt_d = 6'd63;
      end
    end else if (busy_q) begin
      if (mode_q == iaqu_pkg::MODE_SQRT) begin
        a_d = sq_ge ? (a_q - trial) : a_q;
        b_d = sq_ge ? ((b_q >> 1) + c_q) : (b_q >> 1);
        c_d = c_q >> 2;
      end else begin
        a_d = {a_q[62:0], dv_ge};
        b_d = {32'd0, dv_rem[31:0]};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= iaqu_pkg::MODE_SQRT;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign res_o      = (mode_q == iaqu_pkg::MODE_SQRT) ? b_q : a_q;

endmodule
